// File: hdl/msr_pkg.sv
package msr_pkg;

    localparam int DataW  = 16;
    localparam int GainW  = 16;
    localparam int ThrW   = 15;
    localparam int WarmW  = 11;
    localparam int CountW = 12;
    localparam int SumW   = 22;
    localparam int AxisN  = 3;

    typedef logic signed [DataW-1:0] sample_t;
    typedef logic signed [SumW-1:0]  sum_t;
    typedef logic [CountW-1:0]       count_t;
    typedef logic [1:0]              cfg_index_t;
    typedef logic [1:0]              phase_t;

    // register map
    localparam cfg_index_t CFG_GAIN      = 2'd0;
    localparam cfg_index_t CFG_THRESHOLD = 2'd1;
    localparam cfg_index_t CFG_WARMUP    = 2'd2;

    // phase codes
    localparam phase_t PHASE_WARMUP  = 2'd0;
    localparam phase_t PHASE_AVERAGE = 2'd1;
    localparam phase_t PHASE_FILTER  = 2'd2;

    // register reset values
    localparam logic [GainW-1:0] GAIN_RESET      = 16'd655;
    localparam logic [ThrW-1:0]  THRESHOLD_RESET = 15'd100;
    localparam logic [WarmW-1:0] WARMUP_RESET    = 11'd400;

    // accumulator limits
    localparam sum_t SUM_MAX = 22'sh1FFFFF;
    localparam sum_t SUM_MIN = 22'sh200000;

    localparam sample_t SAMPLE_MAX = 16'sh7FFF;
    localparam sample_t SAMPLE_MIN = 16'sh8000;

endpackage

// File: hdl/magnetometer_spike_rejector.sv
// Channel   Direction  Handshake               Payload
// -------   ---------  ----------------------  ---------------------------------------
// in        sink       in_valid / in_stall     raw_x, raw_y, raw_z
// out       source     out_valid / out_stall   out_x, out_y, out_z, phase, spike_mask
// cfg       sink       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Items pass input then output register; one item per clock while out_stall is low.
// The input register feeds one combinational pass (gain multiply, reference select,
// deviation compare) into the output register; the average at the first filtering item
// comes from a constant-reciprocal multiply in parallel with the gain multiply.
// out_stall reaches in_stall only when both registers are full.
// Reset clears the handshake flags, the sample counter, the axis sums, the last outputs
// and restores the register defaults (gain 655, threshold 100, warm-up 400).
module magnetometer_spike_rejector #(
    parameter int AVG_SAMPLES = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // sample input
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [msr_pkg::DataW-1:0] raw_x,
    input  logic signed [msr_pkg::DataW-1:0] raw_y,
    input  logic signed [msr_pkg::DataW-1:0] raw_z,
    // filtered output
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [msr_pkg::DataW-1:0] out_x,
    output logic signed [msr_pkg::DataW-1:0] out_y,
    output logic signed [msr_pkg::DataW-1:0] out_z,
    output logic [1:0]                      phase,
    output logic [msr_pkg::AxisN-1:0]       spike_mask,
    // register writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [1:0]                      cfg_index,
    input  logic [msr_pkg::GainW-1:0]       cfg_data
);

    // Division of the accumulated sum by AVG_SAMPLES: any |sum| at or above
    // 32768*AVG_SAMPLES saturates, so only AbsW bits go into the reciprocal multiply.
    localparam int AvgLog = $clog2(AVG_SAMPLES);
    localparam int AbsW   = 15 + AvgLog;
    localparam int Shift  = AbsW + AvgLog;
    localparam int RecipW = AbsW + 1;
    localparam int ProdW  = AbsW + RecipW;
    localparam logic [RecipW-1:0] Recip =
        RecipW'(((64'd1 << Shift) + 64'(AVG_SAMPLES) - 64'd1) / 64'(AVG_SAMPLES));
    localparam logic [msr_pkg::SumW-1:0] AvgSatLimit =
        msr_pkg::SumW'(64'd32768 * 64'(AVG_SAMPLES));

    // configuration registers
    logic [msr_pkg::GainW-1:0] gain_reg;
    logic [msr_pkg::ThrW-1:0]  thr_reg;
    logic [msr_pkg::WarmW-1:0] warm_reg;

    // input stage
    logic              s1_valid_reg;
    msr_pkg::sample_t  s1_raw_reg [msr_pkg::AxisN];

    // output stage; the value registers double as the previous output per axis
    logic              out_valid_reg;
    msr_pkg::sample_t  out_val_reg [msr_pkg::AxisN];
    msr_pkg::phase_t   phase_reg;
    logic [msr_pkg::AxisN-1:0] mask_reg;

    // filter state
    msr_pkg::count_t   count_reg;
    msr_pkg::sum_t     sum_reg [msr_pkg::AxisN];

    // datapath
    logic              advance;
    msr_pkg::count_t   end_count;
    msr_pkg::phase_t   phase_next;
    msr_pkg::count_t   count_next;
    msr_pkg::sample_t  result_next [msr_pkg::AxisN];
    msr_pkg::sum_t     sum_next [msr_pkg::AxisN];
    logic [msr_pkg::AxisN-1:0] mask_next;

    logic signed [16:0]  axis_in   [msr_pkg::AxisN];
    logic signed [32:0]  gain_prod [msr_pkg::AxisN];
    logic signed [32:0]  gain_quo  [msr_pkg::AxisN];
    msr_pkg::sample_t    scaled    [msr_pkg::AxisN];
    logic signed [22:0]  sum_wide  [msr_pkg::AxisN];
    logic [msr_pkg::SumW-1:0] sum_abs [msr_pkg::AxisN];
    logic [ProdW-1:0]    div_prod  [msr_pkg::AxisN];
    logic [14:0]         avg_mag   [msr_pkg::AxisN];
    msr_pkg::sample_t    avg       [msr_pkg::AxisN];
    msr_pkg::sample_t    ref_val   [msr_pkg::AxisN];
    logic signed [16:0]  dev       [msr_pkg::AxisN];
    logic [16:0]         dev_abs   [msr_pkg::AxisN];

    // handshakes
    assign advance   = s1_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign cfg_ready = 1'b1;

    assign end_count = msr_pkg::CountW'(warm_reg) + msr_pkg::CountW'(AVG_SAMPLES);

    // phase decision against the current warm-up setting
    always_comb
    begin
        if (count_reg < msr_pkg::CountW'(warm_reg))
        begin
            phase_next = msr_pkg::PHASE_WARMUP;
        end
        else if (count_reg < end_count)
        begin
            phase_next = msr_pkg::PHASE_AVERAGE;
        end
        else
        begin
            phase_next = msr_pkg::PHASE_FILTER;
        end

        // counter stops one past end_count, the first filtering count
        if (count_reg <= end_count)
        begin
            count_next = count_reg + 1'b1;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    // per-axis datapath, three independent lanes
    always_comb
    begin
        for (int i = 0; i < msr_pkg::AxisN; i++)
        begin
            // Y and Z are negated at 17 bits so -32768 stays exact
            if (i == 0)
            begin
                axis_in[i] = {s1_raw_reg[i][15], s1_raw_reg[i]};
            end
            else
            begin
                axis_in[i] = 17'sd0 - {s1_raw_reg[i][15], s1_raw_reg[i]};
            end

            // Q8.8 gain, truncate toward zero, saturate
            gain_prod[i] = axis_in[i] * $signed({1'b0, gain_reg});
            gain_quo[i]  = (gain_prod[i] + (gain_prod[i][32] ? 33'sd255 : 33'sd0)) >>> 8;
            if (gain_quo[i] > 33'sd32767)
            begin
                scaled[i] = msr_pkg::SAMPLE_MAX;
            end
            else if (gain_quo[i] < -33'sd32768)
            begin
                scaled[i] = msr_pkg::SAMPLE_MIN;
            end
            else
            begin
                scaled[i] = gain_quo[i][15:0];
            end

            // saturating accumulate
            sum_wide[i] = {sum_reg[i][21], sum_reg[i]} + {{7{scaled[i][15]}}, scaled[i]};
            if (sum_wide[i][22] != sum_wide[i][21])
            begin
                sum_next[i] = sum_wide[i][22] ? msr_pkg::SUM_MIN : msr_pkg::SUM_MAX;
            end
            else
            begin
                sum_next[i] = sum_wide[i][21:0];
            end

            // average: magnitude times reciprocal, sign restored, saturated
            sum_abs[i]  = sum_reg[i][21] ? (22'd0 - sum_reg[i]) : sum_reg[i];
            div_prod[i] = ProdW'(sum_abs[i][AbsW-1:0]) * ProdW'(Recip);
            avg_mag[i]  = div_prod[i][Shift +: 15];
            if (sum_abs[i] >= AvgSatLimit)
            begin
                avg[i] = sum_reg[i][21] ? msr_pkg::SAMPLE_MIN : msr_pkg::SAMPLE_MAX;
            end
            else if (sum_reg[i][21])
            begin
                avg[i] = 16'sd0 - {1'b0, avg_mag[i]};
            end
            else
            begin
                avg[i] = {1'b0, avg_mag[i]};
            end

            // reference: average on the first filtering item, else previous output
            ref_val[i] = (count_reg == end_count) ? avg[i] : out_val_reg[i];
            dev[i]     = {scaled[i][15], scaled[i]} - {ref_val[i][15], ref_val[i]};
            dev_abs[i] = dev[i][16] ? (17'd0 - dev[i]) : dev[i];

            if (phase_next == msr_pkg::PHASE_FILTER && dev_abs[i] > {2'b00, thr_reg})
            begin
                mask_next[i]   = 1'b1;
                result_next[i] = ref_val[i];
            end
            else
            begin
                mask_next[i]   = 1'b0;
                result_next[i] = scaled[i];
            end
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= msr_pkg::GAIN_RESET;
            thr_reg  <= msr_pkg::THRESHOLD_RESET;
            warm_reg <= msr_pkg::WARMUP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                msr_pkg::CFG_GAIN:      gain_reg <= cfg_data;
                msr_pkg::CFG_THRESHOLD: thr_reg  <= cfg_data[msr_pkg::ThrW-1:0];
                msr_pkg::CFG_WARMUP:    warm_reg <= cfg_data[msr_pkg::WarmW-1:0];
                default:                ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_raw_reg[0] <= raw_x;
            s1_raw_reg[1] <= raw_y;
            s1_raw_reg[2] <= raw_z;
        end
    end

    // output register and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            for (int i = 0; i < msr_pkg::AxisN; i++)
            begin
                out_val_reg[i] <= '0;
                sum_reg[i]     <= '0;
            end
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                count_reg     <= count_next;
                for (int i = 0; i < msr_pkg::AxisN; i++)
                begin
                    out_val_reg[i] <= result_next[i];
                    if (phase_next == msr_pkg::PHASE_AVERAGE)
                    begin
                        sum_reg[i] <= sum_next[i];
                    end
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            phase_reg <= phase_next;
            mask_reg  <= mask_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_x      = out_val_reg[0];
    assign out_y      = out_val_reg[1];
    assign out_z      = out_val_reg[2];
    assign phase      = phase_reg;
    assign spike_mask = mask_reg;

`ifndef NO_ASSERTIONS
    // replacement only happens while filtering
    a_mask_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && phase_reg != msr_pkg::PHASE_FILTER) |-> (mask_reg == '0))
        else $error("spike mask set outside filtering phase");

    // warm-up items always advance the counter
    a_count_warm: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && count_reg < msr_pkg::CountW'(warm_reg))
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("sample counter did not advance in warm-up");

    // an item leaving the input register always lands in the output register
    a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("item lost between input and output register");
`endif

endmodule
